// File: sv/tmfo_pkg.sv
package tmfo_pkg;

    // Fixed layout constants
    localparam int unsigned FACE_COUNT = 6;
    localparam int unsigned CUBE_BIT   = 6;

    // Format classes
    localparam logic [1:0] FMT_RGBA32 = 2'd0;
    localparam logic [1:0] FMT_BLK8   = 2'd1;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_RANGE     = 2'd2;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BASE_WIDTH   = 3'd0,
        REG_BASE_HEIGHT  = 3'd1,
        REG_BASE_DEPTH   = 3'd2,
        REG_FORMAT_CLASS = 3'd3,
        REG_LEVEL_COUNT  = 3'd4,
        REG_FACE_FLAGS   = 3'd5,
        REG_HEADER_BYTES = 3'd6,
        REG_SOURCE_BYTES = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] base_width;
        logic [15:0] base_height;
        logic [15:0] base_depth;
        logic [1:0]  format_class;
        logic [4:0]  level_count;
        logic [6:0]  face_flags;
        logic [7:0]  header_bytes;
        logic [31:0] source_bytes;
    } cfg_t;

    // Operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_LEVEL = 2'd0,
        MUL_DEPTH = 2'd1,
        MUL_FACE  = 2'd2
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_FACE,
        S_SUM,
        S_LOAD,
        S_LOAD_NF
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     lvl_clr;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     sum_en;
        logic     load_en;
        logic     load_nf;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic last_level;
        logic out_free;
    } dp_status_t;

endpackage

// File: sv/texture_mip_face_offset_calculator.sv
// Texture layout calculator: finds where one face and mip level of a stored
// texture sits in its source.
// Configure the texture through the cfg channel (cfg_index selects the
// register, cfg_data carries the value) while no request is in flight;
// cfg_ready is always high.
// A request word on the s_axis channel names a face and a mip level. One
// result word per request leaves on the m_axis channel: byte offset, plane
// size and row pitch in tdata, the status code in tuser.
// A request that is not found goes from the check state straight to the load.
// A found request walks every stored level through the one shared 32x16
// multiplier (level product, depth product, accumulate), then forms the face
// product, the offset sum and the range check.
// Requests are handled one at a time.
// The result sits in an output register, so the next request is accepted
// while a stalled result waits; that request's result waits in turn until
// the output register is free.
// Reset clears the configuration to its defaults (depth 1, one level, rest
// zero) and drops any pending result.
module texture_mip_face_offset_calculator
#(
    parameter int MAX_LEVELS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] face_index, [7:3] level_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [31:0] byte_offset, [63:32] plane_bytes,
                                        // [81:64] row_pitch, [87:82] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    tmfo_pkg::cfg_t       cfg;
    tmfo_pkg::cmd_t       cmd;
    tmfo_pkg::dp_status_t dp_status;

    logic [31:0] byte_offset;
    logic [31:0] plane_bytes;
    logic [17:0] row_pitch;

    assign cfg_ready = 1'b1;

    tmfo_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tmfo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    tmfo_dp
    #(
        .MAX_LEVELS (MAX_LEVELS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .dp_status   (dp_status),
        .face_index  (s_axis_tdata[2:0]),
        .level_index (s_axis_tdata[7:3]),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .byte_offset (byte_offset),
        .plane_bytes (plane_bytes),
        .row_pitch   (row_pitch),
        .status      (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, row_pitch, plane_bytes, byte_offset};

endmodule

// File: sv/tmfo_cfg.sv
module tmfo_cfg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [2:0]           wr_index,
    input  logic [31:0]          wr_data,
    output tmfo_pkg::cfg_t       cfg
);

    tmfo_pkg::cfg_t cfg_reg;
    tmfo_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (tmfo_pkg::reg_idx_t'(wr_index))
                tmfo_pkg::REG_BASE_WIDTH:   cfg_next.base_width   = wr_data[15:0];
                tmfo_pkg::REG_BASE_HEIGHT:  cfg_next.base_height  = wr_data[15:0];
                tmfo_pkg::REG_BASE_DEPTH:   cfg_next.base_depth   = wr_data[15:0];
                tmfo_pkg::REG_FORMAT_CLASS: cfg_next.format_class = wr_data[1:0];
                tmfo_pkg::REG_LEVEL_COUNT:  cfg_next.level_count  = wr_data[4:0];
                tmfo_pkg::REG_FACE_FLAGS:   cfg_next.face_flags   = wr_data[6:0];
                tmfo_pkg::REG_HEADER_BYTES: cfg_next.header_bytes = wr_data[7:0];
                tmfo_pkg::REG_SOURCE_BYTES: cfg_next.source_bytes = wr_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg              <= '0;
            cfg_reg.base_depth   <= 16'd1;
            cfg_reg.level_count  <= 5'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/tmfo_ctrl.sv
module tmfo_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tmfo_pkg::dp_status_t   dp_status,
    output tmfo_pkg::cmd_t         cmd
);

    tmfo_pkg::state_t state_reg;
    tmfo_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmfo_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmfo_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tmfo_pkg::S_CHECK;
                end
            end
            tmfo_pkg::S_CHECK:
            begin
                state_next = dp_status.found ? tmfo_pkg::S_MUL1 : tmfo_pkg::S_LOAD_NF;
            end
            tmfo_pkg::S_MUL1: state_next = tmfo_pkg::S_MUL2;
            tmfo_pkg::S_MUL2: state_next = tmfo_pkg::S_ACC;
            tmfo_pkg::S_ACC:
            begin
                state_next = dp_status.last_level ? tmfo_pkg::S_FACE : tmfo_pkg::S_MUL1;
            end
            tmfo_pkg::S_FACE: state_next = tmfo_pkg::S_SUM;
            tmfo_pkg::S_SUM:  state_next = tmfo_pkg::S_LOAD;
            tmfo_pkg::S_LOAD, tmfo_pkg::S_LOAD_NF:
            begin
                if (dp_status.out_free)
                begin
                    state_next = tmfo_pkg::S_IDLE;
                end
            end
            default: state_next = tmfo_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = tmfo_pkg::MUL_LEVEL;
        in_ready    = 1'b0;
        case (state_reg)
            tmfo_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            tmfo_pkg::S_CHECK: cmd.lvl_clr = 1'b1;
            tmfo_pkg::S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tmfo_pkg::MUL_LEVEL;
            end
            tmfo_pkg::S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tmfo_pkg::MUL_DEPTH;
            end
            tmfo_pkg::S_ACC: cmd.acc_en = 1'b1;
            tmfo_pkg::S_FACE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tmfo_pkg::MUL_FACE;
            end
            tmfo_pkg::S_SUM: cmd.sum_en = 1'b1;
            tmfo_pkg::S_LOAD: cmd.load_en = dp_status.out_free;
            tmfo_pkg::S_LOAD_NF:
            begin
                cmd.load_en = dp_status.out_free;
                cmd.load_nf = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// File: sv/tmfo_dp.sv
module tmfo_dp
#(
    parameter int MAX_LEVELS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmfo_pkg::cfg_t         cfg,
    input  tmfo_pkg::cmd_t         cmd,
    output tmfo_pkg::dp_status_t   dp_status,
    input  logic [2:0]             face_index,
    input  logic [4:0]             level_index,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [31:0]            byte_offset,
    output logic [31:0]            plane_bytes,
    output logic [17:0]            row_pitch,
    output logic [1:0]             status
);

    localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam logic [4:0] MAX_CNT = 5'(MAX_LEVELS);

    logic [2:0]       face_reg;
    logic [4:0]       req_level_reg;
    logic [LVL_W-1:0] level_reg;
    logic [31:0]      prod_reg;
    logic [31:0]      chain_reg;
    logic [31:0]      below_reg;
    logic [31:0]      plane_reg;
    logic [17:0]      pitch_reg;
    logic [31:0]      offset_reg;

    logic             out_valid_reg;
    logic [31:0]      out_offset_reg;
    logic [31:0]      out_plane_reg;
    logic [17:0]      out_pitch_reg;
    logic [1:0]       out_status_reg;

    logic [4:0]       cnt_eff;
    logic [4:0]       level_ext;
    logic             is_cube;
    logic             face_ok;
    logic [2:0]       faces_before;
    logic [15:0]      w_sh;
    logic [15:0]      h_sh;
    logic [15:0]      d_sh;
    logic [15:0]      w_lv;
    logic [15:0]      h_lv;
    logic [15:0]      d_lv;
    logic [16:0]      bw_sum;
    logic [16:0]      bh_sum;
    logic [18:0]      pitch_full;
    logic [15:0]      vdim;
    logic [31:0]      mul_a;
    logic [15:0]      mul_b;
    logic [47:0]      mul_full;
    logic [32:0]      plane_end;
    logic             out_free;

    // Request checks
    assign cnt_eff   = (cfg.level_count > MAX_CNT) ? MAX_CNT : cfg.level_count;
    assign level_ext = 5'(level_reg);
    assign is_cube   = cfg.face_flags[tmfo_pkg::CUBE_BIT];

    always_comb
    begin
        if (is_cube)
        begin
            face_ok = (face_reg < 3'(tmfo_pkg::FACE_COUNT)) && cfg.face_flags[face_reg];
        end
        else
        begin
            face_ok = (face_reg == 3'd0);
        end
    end

    // Number of present faces stored ahead of the requested one.
    always_comb
    begin
        faces_before = 3'd0;
        for (int k = 0; k < tmfo_pkg::FACE_COUNT; k++)
        begin
            if ((3'(k) < face_reg) && cfg.face_flags[k])
            begin
                faces_before = faces_before + 3'd1;
            end
        end
        if (!is_cube)
        begin
            faces_before = 3'd0;
        end
    end

    // Dimensions of the level under the counter
    assign w_sh   = cfg.base_width  >> level_reg;
    assign h_sh   = cfg.base_height >> level_reg;
    assign d_sh   = cfg.base_depth  >> level_reg;
    assign w_lv   = (w_sh == 16'd0) ? 16'd1 : w_sh;
    assign h_lv   = (h_sh == 16'd0) ? 16'd1 : h_sh;
    assign d_lv   = (d_sh == 16'd0) ? 16'd1 : d_sh;
    assign bw_sum = {1'b0, w_lv} + 17'd3;
    assign bh_sum = {1'b0, h_lv} + 17'd3;

    always_comb
    begin
        if (cfg.format_class == tmfo_pkg::FMT_RGBA32)
        begin
            pitch_full = {1'b0, w_lv, 2'b00};
            vdim       = h_lv;
        end
        else if (cfg.format_class == tmfo_pkg::FMT_BLK8)
        begin
            pitch_full = {1'b0, bw_sum[16:2], 3'b000};
            vdim       = {1'b0, bh_sum[16:2]};
        end
        else
        begin
            pitch_full = {bw_sum[16:2], 4'b0000};
            vdim       = {1'b0, bh_sum[16:2]};
        end
    end

    // Shared multiplier; only the low 32 bits of a product are kept.
    always_comb
    begin
        case (cmd.mul_sel)
            tmfo_pkg::MUL_LEVEL:
            begin
                mul_a = {13'd0, pitch_full};
                mul_b = vdim;
            end
            tmfo_pkg::MUL_DEPTH:
            begin
                mul_a = prod_reg;
                mul_b = (cfg.format_class == tmfo_pkg::FMT_RGBA32) ? d_lv : 16'd1;
            end
            tmfo_pkg::MUL_FACE:
            begin
                mul_a = chain_reg;
                mul_b = {13'd0, faces_before};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 16'd0;
            end
        endcase
    end

    assign mul_full = {16'd0, mul_a} * {32'd0, mul_b};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            face_reg      <= face_index;
            req_level_reg <= level_index;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_full[31:0];
        end
        if (cmd.lvl_clr)
        begin
            chain_reg <= 32'd0;
            below_reg <= 32'd0;
        end
        else if (cmd.acc_en)
        begin
            chain_reg <= chain_reg + prod_reg;
            if (level_ext < req_level_reg)
            begin
                below_reg <= below_reg + prod_reg;
            end
        end
        if (cmd.acc_en && (level_ext == req_level_reg))
        begin
            plane_reg <= prod_reg;
            pitch_reg <= pitch_full[17:0];
        end
        if (cmd.sum_en)
        begin
            offset_reg <= {24'd0, cfg.header_bytes} + prod_reg + below_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (cmd.lvl_clr)
        begin
            level_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            level_reg <= level_reg + LVL_W'(1);
        end
    end

    // Output register
    assign out_free  = !out_valid_reg || out_ready;
    assign plane_end = {1'b0, offset_reg} + {1'b0, plane_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            if (cmd.load_nf)
            begin
                out_offset_reg <= 32'd0;
                out_plane_reg  <= 32'd0;
                out_pitch_reg  <= 18'd0;
                out_status_reg <= tmfo_pkg::STAT_NOT_FOUND;
            end
            else
            begin
                out_offset_reg <= offset_reg;
                out_plane_reg  <= plane_reg;
                out_pitch_reg  <= pitch_reg;
                out_status_reg <= (plane_end > {1'b0, cfg.source_bytes}) ?
                                  tmfo_pkg::STAT_RANGE : tmfo_pkg::STAT_OK;
            end
        end
    end

    assign dp_status.found      = (req_level_reg < cnt_eff) && face_ok;
    assign dp_status.last_level = (level_ext == (cnt_eff - 5'd1));
    assign dp_status.out_free   = out_free;

    assign out_valid   = out_valid_reg;
    assign byte_offset = out_offset_reg;
    assign plane_bytes = out_plane_reg;
    assign row_pitch   = out_pitch_reg;
    assign status      = out_status_reg;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_en |-> out_free)
        else $error("result loaded over an unaccepted word");

    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == tmfo_pkg::STAT_NOT_FOUND)) |->
        ((out_offset_reg == 32'd0) && (out_plane_reg == 32'd0) && (out_pitch_reg == 18'd0)))
        else $error("not-found result carries nonzero fields");

    a_acc_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_en |-> (!cmd.mul_en && !cmd.load_en))
        else $error("accumulate overlaps a multiply or a load");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_en |-> (level_ext < cnt_eff))
        else $error("level counter ran past the level count");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

localparam int unsigned LEVEL_CAP     = 16;
localparam logic [1:0]  FMT_BLK16     = 2'd2;
localparam logic [1:0]  FMT_RESERVED  = 2'd3;
localparam int          CYCLE_LIMIT   = 800000;
localparam int          RANDOM_ITEMS  = 1200;
localparam int          DRAIN_CYCLES  = 60;
localparam int          LONG_HOLD     = 400;

// One result word as the block reports it.
typedef struct packed {
    logic [31:0] offset;
    logic [31:0] plane;
    logic [17:0] pitch;
    logic [1:0]  status;
} plane_place_t;

// Raw register write data; upper bits may carry junk that the block must mask.
typedef struct {
    logic [31:0] width_px;
    logic [31:0] height_px;
    logic [31:0] depth_px;
    logic [31:0] fmt;
    logic [31:0] levels;
    logic [31:0] faces;
    logic [31:0] hdr;
    logic [31:0] src;
} texture_cfg_t;

typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_RHYTHM} rx_mode_t;

class plane_layout_board;
    logic [15:0]  width_px;
    logic [15:0]  height_px;
    logic [15:0]  depth_px;
    logic [1:0]   fmt;
    logic [4:0]   levels;
    logic [6:0]   faces;
    logic [7:0]   hdr;
    logic [31:0]  src_len;
    plane_place_t expected_planes[$];
    int           mismatches;
    int           checked;
    int           ok_count;
    int           missing_count;
    int           overrun_count;

    function new();
        width_px      = '0;
        height_px     = '0;
        depth_px      = 16'd1;
        fmt           = tmfo_pkg::FMT_RGBA32;
        levels        = 5'd1;
        faces         = '0;
        hdr           = '0;
        src_len       = '0;
        mismatches    = 0;
        checked       = 0;
        ok_count      = 0;
        missing_count = 0;
        overrun_count = 0;
    endfunction

    function void write_reg(tmfo_pkg::reg_idx_t idx, logic [31:0] data);
        case (idx)
            tmfo_pkg::REG_BASE_WIDTH:   width_px  = data[15:0];
            tmfo_pkg::REG_BASE_HEIGHT:  height_px = data[15:0];
            tmfo_pkg::REG_BASE_DEPTH:   depth_px  = data[15:0];
            tmfo_pkg::REG_FORMAT_CLASS: fmt       = data[1:0];
            tmfo_pkg::REG_LEVEL_COUNT:  levels    = data[4:0];
            tmfo_pkg::REG_FACE_FLAGS:   faces     = data[6:0];
            tmfo_pkg::REG_HEADER_BYTES: hdr       = data[7:0];
            tmfo_pkg::REG_SOURCE_BYTES: src_len   = data;
            default:                    ;
        endcase
    endfunction

    function int pending();
        return expected_planes.size();
    endfunction

    // Bytes of one mip level, wrapped to 32 bits, and its unwrapped row pitch.
    function logic [31:0] level_bytes(int unsigned lvl, output logic [31:0] pitch_full);
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] d;
        logic [63:0] pitch;
        logic [63:0] bytes;
        w = {48'd0, width_px} >> lvl;
        h = {48'd0, height_px} >> lvl;
        d = {48'd0, depth_px} >> lvl;
        if (w == 64'd0) w = 64'd1;
        if (h == 64'd0) h = 64'd1;
        if (d == 64'd0) d = 64'd1;
        if (fmt == tmfo_pkg::FMT_RGBA32)
        begin
            pitch = w * 64'd4;
            bytes = (pitch * h) & 64'hFFFF_FFFF;
            bytes = (bytes * d) & 64'hFFFF_FFFF;
        end
        else
        begin
            // Both sixteen-byte codes use the same block size; depth plays no part.
            pitch = ((w + 64'd3) / 64'd4) * ((fmt == tmfo_pkg::FMT_BLK8) ? 64'd8 : 64'd16);
            bytes = (pitch * ((h + 64'd3) / 64'd4)) & 64'hFFFF_FFFF;
        end
        pitch_full = pitch[31:0];
        return bytes[31:0];
    endfunction

    function void note_request(logic [2:0] face, logic [4:0] lvl);
        plane_place_t want;
        int unsigned  count;
        int unsigned  i;
        logic         cube;
        logic         found;
        logic [31:0]  chain;
        logic [31:0]  below;
        logic [31:0]  faces_before;
        logic [31:0]  sz;
        logic [31:0]  pitch_full;
        logic [32:0]  plane_end;
        count = (levels > LEVEL_CAP) ? LEVEL_CAP : levels;
        cube  = faces[tmfo_pkg::CUBE_BIT];
        found = (lvl < count);
        if (cube)
        begin
            if (face >= tmfo_pkg::FACE_COUNT || !faces[face]) found = 1'b0;
        end
        else if (face != 3'd0)
        begin
            found = 1'b0;
        end
        want = '0;
        if (!found)
        begin
            want.status = tmfo_pkg::STAT_NOT_FOUND;
            missing_count++;
        end
        else
        begin
            chain        = '0;
            below        = '0;
            faces_before = '0;
            for (i = 0; i < count; i++)
            begin
                sz = level_bytes(i, pitch_full);
                if (i < lvl) below += sz;
                chain += sz;
            end
            if (cube)
            begin
                for (i = 0; i < face; i++)
                    faces_before += faces[i];
            end
            want.plane  = level_bytes(lvl, pitch_full);
            want.offset = hdr + chain * faces_before + below;
            want.pitch  = pitch_full[17:0];
            // The end of the plane is judged on 33 bits, without wrap.
            plane_end   = {1'b0, want.offset} + {1'b0, want.plane};
            if (plane_end > {1'b0, src_len})
            begin
                want.status = tmfo_pkg::STAT_RANGE;
                overrun_count++;
            end
            else
            begin
                want.status = tmfo_pkg::STAT_OK;
                ok_count++;
            end
        end
        expected_planes.push_back(want);
    endfunction

    function void check_placement(logic [87:0] data, logic [1:0] user);
        plane_place_t got;
        plane_place_t want;
        got.offset = data[31:0];
        got.plane  = data[63:32];
        got.pitch  = data[81:64];
        got.status = user;
        checked++;
        if (expected_planes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: unexpected result word: offset %h plane %h pitch %h status %0d",
                         got.offset, got.plane, got.pitch, got.status);
            return;
        end
        want = expected_planes.pop_front();
        if (got.offset !== want.offset || got.plane !== want.plane ||
            got.pitch !== want.pitch || got.status !== want.status)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("tb: mismatch on result %0d", checked);
                $display("    expected offset %h plane %h pitch %h status %0d",
                         want.offset, want.plane, want.pitch, want.status);
                $display("    actual   offset %h plane %h pitch %h status %0d",
                         got.offset, got.plane, got.pitch, got.status);
            end
        end
    endfunction
endclass

module tb;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    plane_layout_board board = new();
    texture_cfg_t      cur;
    int                texture_count = 0;
    int                hold_requests = 0;
    int                hold_served   = 0;
    int                cycle_count   = 0;

    texture_mip_face_offset_calculator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic texture_cfg_t make_texture(logic [31:0] w, logic [31:0] h,
                                                  logic [31:0] d, logic [31:0] f,
                                                  logic [31:0] lv, logic [31:0] ff,
                                                  logic [31:0] hb, logic [31:0] sb);
        texture_cfg_t t;
        t.width_px  = w;
        t.height_px = h;
        t.depth_px  = d;
        t.fmt       = f;
        t.levels    = lv;
        t.faces     = ff;
        t.hdr       = hb;
        t.src       = sb;
        return t;
    endfunction

    // Now and then set bits above the register width; the block has to drop them.
    function automatic logic [31:0] with_junk(logic [31:0] value, int unsigned bits);
        logic [31:0] junk;
        junk = $urandom();
        if ($urandom_range(0, 3) == 0)
            return value | (junk << bits);
        return value;
    endfunction

    function automatic logic [31:0] random_dim();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd65535;
            2:       return $urandom_range(65533, 65535);
            3:       return $urandom_range(1, 8);
            default: return $urandom_range(0, 65535) >> $urandom_range(0, 15);
        endcase
    endfunction

    function automatic texture_cfg_t random_texture();
        texture_cfg_t t;
        logic [31:0]  ff;
        logic [31:0]  sb;
        ff    = $urandom_range(0, 127);
        ff[6] = ($urandom_range(0, 4) < 3);
        case ($urandom_range(0, 5))
            0:       sb = 32'hFFFF_FFFF;
            1:       sb = 32'd0;
            default: sb = $urandom() >> $urandom_range(0, 31);
        endcase
        t = make_texture(random_dim(), random_dim(), random_dim(),
                         $urandom_range(0, 3),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 16),
                         ff,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(149, 255)
                                                     : $urandom_range(0, 148),
                         sb);
        t.width_px  = with_junk(t.width_px, 16);
        t.height_px = with_junk(t.height_px, 16);
        t.depth_px  = with_junk(t.depth_px, 16);
        t.fmt       = with_junk(t.fmt, 2);
        t.levels    = with_junk(t.levels, 5);
        t.faces     = with_junk(t.faces, 7);
        t.hdr       = with_junk(t.hdr, 8);
        return t;
    endfunction

    // Mostly requests that hit a stored plane, the rest anything the fields allow.
    task automatic pick_request(output logic [2:0] face, output logic [4:0] lvl);
        int unsigned count;
        logic        cube;
        count = (cur.levels[4:0] > LEVEL_CAP) ? LEVEL_CAP : cur.levels[4:0];
        cube  = cur.faces[tmfo_pkg::CUBE_BIT];
        if ($urandom_range(0, 3) != 0 && count != 0 && (!cube || cur.faces[5:0] != 0))
        begin
            lvl = 5'($urandom_range(0, count - 1));
            face = 3'd0;
            if (cube)
            begin
                do
                    face = 3'($urandom_range(0, tmfo_pkg::FACE_COUNT - 1));
                while (!cur.faces[face]);
            end
        end
        else
        begin
            face = 3'($urandom_range(0, 7));
            lvl  = 5'($urandom_range(0, 31));
        end
    endtask

    task automatic write_reg(input tmfo_pkg::reg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic program_texture(input texture_cfg_t t);
        write_reg(tmfo_pkg::REG_BASE_WIDTH,   t.width_px);
        write_reg(tmfo_pkg::REG_BASE_HEIGHT,  t.height_px);
        write_reg(tmfo_pkg::REG_BASE_DEPTH,   t.depth_px);
        write_reg(tmfo_pkg::REG_FORMAT_CLASS, t.fmt);
        write_reg(tmfo_pkg::REG_LEVEL_COUNT,  t.levels);
        write_reg(tmfo_pkg::REG_FACE_FLAGS,   t.faces);
        write_reg(tmfo_pkg::REG_HEADER_BYTES, t.hdr);
        write_reg(tmfo_pkg::REG_SOURCE_BYTES, t.src);
        cfg_valid <= 1'b0;
        cur = t;
        texture_count++;
    endtask

    // Leaves tvalid high so that back-to-back words need no gap.
    task automatic send_word(input logic [2:0] face, input logic [4:0] lvl);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lvl, face};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(face, lvl);
    endtask

    task automatic wait_drain();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Receiver: changes its stall pattern every so often, with one long hold on request.
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       beat;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_requests != hold_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_served++;
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(10, 150);
            for (beat = 0; beat < span; beat++)
            begin
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ((beat % 8) < 5);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_placement(m_axis_tdata, m_axis_tuser);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: timed out after %0d cycles, %0d results outstanding",
                 cycle_count, board.pending());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [2:0] face;
        logic [4:0] lvl;
        int         phase_no;
        int         phase_len;
        int         sent;
        int         burst;
        int         gap;
        int         k;
        int         random_sent;
        bit         paused;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= tmfo_pkg::REG_BASE_WIDTH;
        cfg_data      <= '0;
        cur = make_texture(0, 0, 1, tmfo_pkg::FMT_RGBA32, 1, 0, 0, 0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: zero size clamps to one pixel, and it overruns an empty source.
        send_word(3'd0, 5'd0);
        send_word(3'd1, 5'd0);
        send_word(3'd0, 5'd1);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        // Largest volume, full chain, all faces; sizes wrap.
        program_texture(make_texture(65535, 65535, 65535, tmfo_pkg::FMT_RGBA32, 16, 7'h7F,
                                     148, 32'hFFFF_FFFF));
        send_word(3'd0, 5'd0);
        send_word(3'd5, 5'd15);
        send_word(3'd6, 5'd0);
        send_word(3'd7, 5'd31);
        send_word(3'd3, 5'd16);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        // Block pitch of 262144 wraps to zero in the pitch field.
        program_texture(make_texture(65535, 4, 1, FMT_BLK16, 1, 0, 0, 32'hFFFF_FFFF));
        send_word(3'd0, 5'd0);
        send_word(3'd1, 5'd0);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        // Reserved format code, level count above the cap, cube with gaps in its faces.
        program_texture(make_texture(300, 17, 5, FMT_RESERVED, 32'hABCD_0011,
                                     7'h40 | 7'b010110, 0, 32'h0000_1000));
        send_word(3'd0, 5'd3);
        send_word(3'd1, 5'd2);
        send_word(3'd4, 5'd15);
        send_word(3'd6, 5'd1);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        // No levels at all, and a cube with no face present.
        program_texture(make_texture(5, 3, 1, tmfo_pkg::FMT_BLK8, 0, 7'h40, 148,
                                     32'hFFFF_FFFF));
        send_word(3'd0, 5'd0);
        send_word(3'd2, 5'd0);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        // Zero depth, smallest size, header write with junk above eight bits.
        program_texture(make_texture(1, 1, 0, tmfo_pkg::FMT_BLK8, 3, 7'h7F, 32'h0000_01FF,
                                     32'd1000));
        send_word(3'd5, 5'd2);
        send_word(3'd4, 5'd0);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        random_sent = 0;
        phase_no    = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(60, 140);
            program_texture(random_texture());
            // One phase runs against a long receiver hold so the input backs up.
            if (phase_no == 2)
                hold_requests++;
            sent   = 0;
            paused = 1'b0;
            while (sent < phase_len)
            begin
                burst = $urandom_range(1, 16);
                for (k = 0; k < burst && sent < phase_len; k++)
                begin
                    pick_request(face, lvl);
                    send_word(face, lvl);
                    sent++;
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (phase_no == 5 && !paused && sent >= phase_len / 2)
                begin
                    s_axis_tvalid <= 1'b0;
                    wait_drain();
                    paused = 1'b1;
                end
                else if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            s_axis_tvalid <= 1'b0;
            wait_drain();
            random_sent += sent;
            phase_no++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d requests over %0d texture settings",
                 board.checked, texture_count);
        $display("tb: %0d ok, %0d not found, %0d past end, %0d mismatches, %0d still expected",
                 board.ok_count, board.missing_count, board.overrun_count,
                 board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
